### rtl/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg: shared sizes and types of the moving average filter
// Holds the data widths, the window limits and the request and response
// bundles that pass between the filter control and the serial divider.
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WINDOW  = 64;
    localparam int ADDR_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W       = 7;
    localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
    localparam int STEP_W      = $clog2(SUM_W);

    localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(10);

    // Division request: start pulse, signed window sum and sample count.
    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    // Division response: done pulse and the quotient truncated toward zero.
    typedef struct packed {
        logic                          done;
        logic signed [SAMPLE_BITS-1:0] quot;
    } t_div_rsp;

endpackage

### rtl/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter: windowed mean of signed samples with warm-up
// Keeps the last window_size samples in a ring RAM with their running sum
// and returns the sum divided by the number of samples in the window.
//
//   Channel   Dir   Transaction carries
//   s_axis    in    tdata = sample[15:0]; tuser = restart
//   m_axis    out   tdata = mean[15:0]
//   cfg       in    wr_data = window_size[6:0], written when wr_en is high while idle
//
// An item passes from acceptance through the ring RAM read, the sum update,
// the divider launch and the bit-serial divider (one quotient bit per
// cycle) before its result is loaded into the output register. A restart
// item skips the update and the divider and loads a zero result.
// Reset is synchronous and active low; the ring RAM is not cleared, since the
// sample count guarantees that only entries written since the last clear
// are ever read back. A stalled output holds the finished result, and the
// block accepts the next transaction as soon as the previous result is
// loaded into the output register.
// ----------------------------------------------------------------------------
module moving_average_filter
    import maf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream: tdata = {sample}, tuser = {restart}.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] i_s_axis_tdata,
    input  logic                   i_s_axis_tuser,
    // Output stream: tdata = {mean}.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [SAMPLE_BITS-1:0] o_m_axis_tdata,
    // Window size register: tdata-style data = {window_size}.
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_W-1:0]       i_cfg_wr_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_START  = 5'b00100,
        S_DIV    = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]              r_window_size, n_window_size;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic [ADDR_W-1:0]             r_wpos, n_wpos;
    logic [CNT_W-1:0]              r_seen, n_seen;
    logic                          r_full, n_full;
    logic signed [SAMPLE_BITS-1:0] r_x, n_x;
    logic [CNT_W-1:0]              r_dvsr, n_dvsr;
    logic signed [SAMPLE_BITS-1:0] r_res, n_res;
    logic                          r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0]        r_out_data, n_out_data;

    logic                          in_accept;
    logic [CNT_W-1:0]              w_eff;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS:0]   delta;
    logic [CNT_W-1:0]              seen_upd;
    logic [CNT_W-1:0]              pos_inc;
    logic                          full_upd;
    logic                          out_free;
    t_div_req                      div_req;
    t_div_rsp                      div_rsp;

    // Effective window: a zero size acts as one, and sizes beyond the ring
    // saturate at the ring depth.
    always_comb begin
        priority if (r_window_size == '0) begin
            w_eff = CNT_W'(1);
        end else if (int'(r_window_size) > MAX_WINDOW) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(r_window_size);
        end
    end

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Once the window is full the oldest sample leaves the sum as the new
    // one enters; before that the sample count grows instead.
    assign delta    = r_full ? ((SAMPLE_BITS+1)'(r_x) - (SAMPLE_BITS+1)'($signed(ram_rdata)))
                             : (SAMPLE_BITS+1)'(r_x);
    assign seen_upd = r_full ? r_seen : r_seen + CNT_W'(1);
    assign pos_inc  = CNT_W'(r_wpos) + CNT_W'(1);
    assign full_upd = r_full || (seen_upd >= w_eff);

    always_comb begin
        n_state       = r_state;
        n_window_size = r_window_size;
        n_sum         = r_sum;
        n_wpos        = r_wpos;
        n_seen        = r_seen;
        n_full        = r_full;
        n_x           = r_x;
        n_dvsr        = r_dvsr;
        n_res         = r_res;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_wr_en) begin
                    // A new window size starts the filter from scratch. A
                    // transaction taken at the same edge is the first one of
                    // the new window, since the update reads the cleared state.
                    n_window_size = i_cfg_wr_data;
                    n_sum         = '0;
                    n_wpos        = '0;
                    n_seen        = '0;
                    n_full        = 1'b0;
                end
                if (in_accept) begin
                    n_x = $signed(i_s_axis_tdata);
                    if (i_s_axis_tuser) begin
                        n_sum   = '0;
                        n_wpos  = '0;
                        n_seen  = '0;
                        n_full  = 1'b0;
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                n_sum   = r_sum + SUM_W'(delta);
                n_seen  = seen_upd;
                n_full  = full_upd;
                n_wpos  = (pos_inc >= w_eff) ? '0 : pos_inc[ADDR_W-1:0];
                n_dvsr  = full_upd ? w_eff : seen_upd;
                n_state = S_START;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res   = div_rsp.quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_size <= WIN_RESET;
            r_sum         <= '0;
            r_wpos        <= '0;
            r_seen        <= '0;
            r_full        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_window_size <= n_window_size;
            r_sum         <= n_sum;
            r_wpos        <= n_wpos;
            r_seen        <= n_seen;
            r_full        <= n_full;
            r_out_valid   <= n_out_valid;
        end
        r_x        <= n_x;
        r_dvsr     <= n_dvsr;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // The oldest sample is read when the item is accepted and overwritten
    // with the new one in the following cycle.
    maf_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(MAX_WINDOW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (r_state == S_UPDATE),
        .i_waddr(r_wpos),
        .i_wdata(r_x),
        .i_re   (in_accept),
        .i_raddr(r_wpos),
        .o_rdata(ram_rdata)
    );

    assign div_req.start    = (r_state == S_START);
    assign div_req.dividend = r_sum;
    assign div_req.divisor  = r_dvsr;

    maf_serial_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // A full window has seen exactly as many samples as it holds.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_seen == w_eff))
        else $error("full window with wrong sample count");

    // Before the window fills, the count stays below the window size.
    a_warm_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_full |-> (r_seen < w_eff))
        else $error("warm-up count reached window size without full flag");

    // The write position always lies inside the active window.
    a_wpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_wpos) < w_eff)
        else $error("write position outside window");

    // The divider reports completion only while the control waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the division state");

    // The divisor handed to the divider is never zero.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_dvsr != '0))
        else $error("zero divisor launched");

endmodule

### rtl/maf_ram.sv
// ----------------------------------------------------------------------------
// maf_ram: generic single-clock RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/maf_serial_div.sv
// ----------------------------------------------------------------------------
// maf_serial_div: bit-serial signed divider
// Restoring division of the window sum magnitude by the sample count, one
// quotient bit per cycle, with the sign restored on the way out.
// ----------------------------------------------------------------------------
module maf_serial_div
    import maf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic [SUM_W-1:0]   r_shift, n_shift;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_dvsr, n_dvsr;

    logic [CNT_W:0]     rem_sh;
    logic [CNT_W:0]     rem_diff;
    logic               rem_ge;
    logic [SUM_W-1:0]   dvd_mag;
    logic [SAMPLE_BITS-1:0] q_mag;

    // The dividend magnitude leaves the top of the shift register while
    // quotient bits enter at the bottom.
    assign rem_sh   = {r_rem, r_shift[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvsr};
    assign rem_ge   = (rem_sh >= {1'b0, r_dvsr});
    assign dvd_mag  = i_req.dividend[SUM_W-1] ? SUM_W'(-i_req.dividend)
                                              : SUM_W'(i_req.dividend);

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_shift = r_shift;
        n_rem   = r_rem;
        n_dvsr  = r_dvsr;
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_cnt   = STEP_W'(SUM_W - 1);
            n_neg   = i_req.dividend[SUM_W-1];
            n_shift = dvd_mag;
            n_rem   = '0;
            n_dvsr  = i_req.divisor;
        end else if (r_busy) begin
            n_shift = {r_shift[SUM_W-2:0], rem_ge};
            n_rem   = rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            n_cnt   = r_cnt - STEP_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg   <= n_neg;
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_dvsr  <= n_dvsr;
    end

    // The quotient always fits the sample range, so its low bits carry it.
    assign q_mag      = r_shift[SAMPLE_BITS-1:0];
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -q_mag : q_mag;

endmodule
